>>> sv/uvol_pkg.sv
// Shared types and constants for the unique value ordered list.
package uvol_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FIRST  = 2'd2,
        OP_NEXT   = 2'd3
    } t_opcode;

    typedef logic signed [VALUE_W-1:0] t_value;

endpackage

>>> sv/unique_value_ordered_list_top.sv
// Top level: insertion-ordered set of distinct values with a cursor, scanned from memory.
// Insert and lookup read the stored entries one per cycle, then give their result.
// A successful get reads its entry from the table, a failing get does not;
// one word is handled at a time.
// Reset is synchronous and active low; it clears the fill count and the cursor and
// leaves the entry table undefined, with no clearing pass. The receiver cannot stall.
module unique_value_ordered_list_top #(
    parameter int CAPACITY = uvol_pkg::DEFAULT_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_opcode,
    input  uvol_pkg::t_value i_item_value,
    output logic             o_valid,
    output logic             o_ok,
    output uvol_pkg::t_value o_out_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GET
    } t_state;

    t_state           r_state, n_state;
    uvol_pkg::t_opcode r_op, n_op;
    uvol_pkg::t_value r_value, n_value;
    logic [CW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [CW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pidx, n_pidx;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_gidx, n_gidx;
    logic             r_valid, n_valid;
    logic             r_ok, n_ok;
    uvol_pkg::t_value r_out, n_out;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    uvol_pkg::t_value rd_data;
    logic [CW-1:0]    next_pos;
    logic             match;

    uvol_mem #(
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(r_value),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign next_pos = CW'(r_cursor) + CW'(1);
    assign match    = r_pend && (rd_data == r_value);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_value  = r_value;
        n_fill   = r_fill;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_gidx   = r_gidx;
        n_valid  = 1'b0;
        n_ok     = 1'b0;
        n_out    = '0;
        wr_en    = 1'b0;
        wr_addr  = r_fill[AW-1:0];
        rd_en    = 1'b0;
        rd_addr  = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = uvol_pkg::t_opcode'(i_opcode);
                    n_value = i_item_value;
                    unique case (uvol_pkg::t_opcode'(i_opcode))
                        uvol_pkg::OP_INSERT, uvol_pkg::OP_LOOKUP: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                        uvol_pkg::OP_FIRST: begin
                            if (r_fill != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_gidx  = '0;
                                n_state = S_GET;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        uvol_pkg::OP_NEXT: begin
                            if (r_fill != '0 && next_pos < r_fill) begin
                                rd_en   = 1'b1;
                                rd_addr = next_pos[AW-1:0];
                                n_gidx  = next_pos[AW-1:0];
                                n_state = S_GET;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (match) begin
                    n_cursor = r_pidx;
                    n_ok     = (r_op == uvol_pkg::OP_LOOKUP);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_idx < r_fill) begin
                    rd_en   = 1'b1;
                    n_pidx  = r_idx[AW-1:0];
                    n_pend  = 1'b1;
                    n_idx   = r_idx + CW'(1);
                end else begin
                    n_cursor = '0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    if (r_op == uvol_pkg::OP_INSERT && r_fill < CW'(CAPACITY)) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + CW'(1);
                        n_ok   = 1'b1;
                    end
                end
            end
            S_GET: begin
                n_cursor = r_gidx;
                n_ok     = 1'b1;
                n_out    = rd_data;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cursor <= '0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
        end
        r_op    <= n_op;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_gidx  <= n_gidx;
        r_ok    <= n_ok;
        r_out   <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_ok        = r_ok;
    assign o_out_value = r_out;

endmodule

>>> sv/uvol_mem.sv
// Entry table: one write port and one registered read port.
module uvol_mem #(
    parameter int DEPTH = uvol_pkg::DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  uvol_pkg::t_value i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output uvol_pkg::t_value o_rd_data
);

    uvol_pkg::t_value r_mem [DEPTH];
    uvol_pkg::t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
